/* rtl/dtq_pkg.sv */
// shared types and constants for the drop-tail queue delay model
// no dependencies; imported by every module of the block
`default_nettype none

package dtq_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;

  localparam int TIME_W   = 48;
  localparam int BYTES_W  = 16;
  localparam int CAP_W    = 9;
  localparam int BTIME_W  = 16;
  localparam int PROD_W   = BYTES_W + BTIME_W;
  localparam int DEPTH_W  = 9;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 64;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 192;

  localparam logic [CAP_W-1:0]   CAPACITY_RST  = 9'd200;
  localparam logic [BTIME_W-1:0] BYTE_TIME_RST = 16'd727;

  // configuration register indexes
  typedef enum logic {
    REG_CAPACITY  = 1'b0,
    REG_BYTE_TIME = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_ADD,
    ST_SUB,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [TIME_W-1:0]   a;
    logic [TIME_W-1:0]   b;
  } alu_req_t;

endpackage

`default_nettype wire

/* rtl/dtq_alu.sv */
// shared 48-bit add/subtract unit with carry out
// depends on dtq_pkg for the request struct
`default_nettype none

module dtq_alu (
  input  var dtq_pkg::alu_req_t                req,
  output logic [dtq_pkg::TIME_W-1:0]           res,
  output logic                                 carry
);
  import dtq_pkg::*;

  logic [TIME_W:0] sum;
  logic [TIME_W-1:0] b_in;

  // subtract is a + ~b + 1; carry set means no borrow
  always_comb begin
    b_in = (req.op == ALU_SUB) ? ~req.b : req.b;
    sum = {1'b0, req.a} + {1'b0, b_in} + {{TIME_W{1'b0}}, (req.op == ALU_SUB)};
    res = sum[TIME_W-1:0];
    carry = sum[TIME_W];
  end

endmodule

`default_nettype wire

/* rtl/dtq_ring.sv */
// departure time ring: one write port, one registered read port
// depends on dtq_pkg for the time width
`default_nettype none

module dtq_ring #(
  parameter int DEPTH = dtq_pkg::BUFFER_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [IDX_W-1:0]               wr_addr,
  input  wire logic [dtq_pkg::TIME_W-1:0]     wr_data,
  input  wire logic [IDX_W-1:0]               rd_addr,
  output logic      [dtq_pkg::TIME_W-1:0]     rd_data
);
  import dtq_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/drop_tail_queue_delay_model_core.sv */
// drop-tail queue delay model, one request at a time through a shared adder.
// after a request is taken the pop loop reads one ring entry per cycle through
// the ring's read port, popping departed ones; a dropped packet then goes to the
// result state, a queued one first passes the add, subtract and sum states. a new
// input request is taken only in idle, after the result is loaded past any stall.
// rst is synchronous: queue empty, counters zero, capacity 200, byte_time 727.
`default_nettype none

module drop_tail_queue_delay_model_core #(
  parameter int BUFFER_DEPTH = dtq_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [dtq_pkg::BTIME_W-1:0]         cfg_data,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // arrival_time[47:0], packet_bytes[63:48]
  input  wire logic [dtq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // packet_delay[47:0], queue_depth[56:48], total_packets[88:57],
  // lost_packets[120:89], total_delay[184:121], zero[191:185]
  output logic [dtq_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // dropped[0]
  output logic                                     m_axis_tuser
);
  import dtq_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int PAD_W = OUT_TDATA_W - (TIME_W + DEPTH_W + 2 * CNT_W + SUM_W);

  state_t state, state_next;

  logic [CAP_W-1:0]   capacity;
  logic [BTIME_W-1:0] byte_time;

  logic [TIME_W-1:0]  arrival;
  logic [PROD_W-1:0]  prod;
  logic [TIME_W-1:0]  dep;
  logic [TIME_W-1:0]  delay;
  logic [TIME_W-1:0]  last_dep;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail;
  logic [OCC_W-1:0]   occ;
  logic               drop;
  logic [CNT_W-1:0]   pkt_cnt;
  logic [CNT_W-1:0]   loss_cnt;
  logic [SUM_W-1:0]   delay_sum;

  alu_req_t           alu_req;
  logic [TIME_W-1:0]  alu_res;
  logic               alu_carry;
  logic [TIME_W-1:0]  rd_data;

  logic accept, pop, drop_now, push, load_out, full;

  dtq_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_carry)
  );

  dtq_ring #(
    .DEPTH (BUFFER_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (dep),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  // buffer full against the smaller of capacity and depth
  assign full = (occ == OCC_W'(BUFFER_DEPTH)) ||
                (CMP_W'(occ) >= CMP_W'(capacity));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    pop           = 1'b0;
    drop_now      = 1'b0;
    push          = 1'b0;
    load_out      = 1'b0;
    alu_req.op    = ALU_SUB;
    alu_req.a     = rd_data;
    alu_req.b     = arrival;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        accept = s_axis_tvalid;
        if (accept) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        // head entry earlier than arrival when the subtract borrows
        if ((occ != '0) && !alu_carry) begin
          pop = 1'b1;
        end else if (full) begin
          drop_now = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = (occ == '0) ? arrival : last_dep;
        alu_req.b  = TIME_W'(prod);
        state_next = ST_SUB;
      end
      ST_SUB: begin
        alu_req.a  = dep;
        alu_req.b  = arrival;
        push       = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RST;
      byte_time <= BYTE_TIME_RST;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      last_dep  <= '0;
      pkt_cnt   <= '0;
      loss_cnt  <= '0;
      delay_sum <= '0;
      drop      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CAPACITY:  capacity  <= cfg_data[CAP_W-1:0];
          REG_BYTE_TIME: byte_time <= cfg_data;
          default: ;
        endcase
      end
      head <= head_next;
      if (accept) begin
        pkt_cnt <= pkt_cnt + CNT_W'(1);
        drop    <= 1'b0;
      end
      if (pop) begin
        occ <= occ - OCC_W'(1);
      end
      if (drop_now) begin
        drop     <= 1'b1;
        loss_cnt <= loss_cnt + CNT_W'(1);
      end
      if (push) begin
        tail     <= (tail == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : tail + IDX_W'(1);
        occ      <= occ + OCC_W'(1);
        last_dep <= dep;
      end
      if (state == ST_SUM) begin
        delay_sum <= delay_sum + SUM_W'(delay);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      arrival <= s_axis_tdata[TIME_W-1:0];
      prod    <= PROD_W'(s_axis_tdata[TIME_W +: BYTES_W]) * PROD_W'(byte_time);
    end
    if (state == ST_ADD) begin
      // saturate on overflow past 48 bits
      dep <= alu_carry ? {TIME_W{1'b1}} : alu_res;
    end
    if (state == ST_SUB) begin
      delay <= alu_carry ? alu_res : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= drop;
      m_axis_tdata <= {{PAD_W{1'b0}}, delay_sum, loss_cnt, pkt_cnt,
                       DEPTH_W'(occ), (drop ? {TIME_W{1'b0}} : delay)};
    end
  end

endmodule

`default_nettype wire

/* rtl/dtq_checker.sv */
// port-level checks for the drop-tail queue delay model
// depends on dtq_pkg; bound to drop_tail_queue_delay_model_core below
`default_nettype none

module dtq_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [dtq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tuser
);
  import dtq_pkg::*;

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // one request at a time: ready drops after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a request");

  // a dropped packet reports zero delay
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[TIME_W-1:0] == '0))
    else $error("dropped packet with nonzero delay");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind drop_tail_queue_delay_model_core dtq_checker u_dtq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
